[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros shared by the framer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold on every rising clock edge outside reset
`define ECSF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("framer assertion failed");
// same-cycle implication
`define ECSF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer assertion failed");
`else
`define ECSF_ASSERT(lbl, clk, rst, prop)
`define ECSF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/ecsf_pkg.sv]
// ---------------------------------------------------------------------------
// ecsf_pkg
// types, link codes and crc/escape helpers for the escaped crc subpacket
// framer
// ---------------------------------------------------------------------------
`default_nettype none

package ecsf_pkg;

   // input op codes
   localparam logic [1:0] OP_BYTE     = 2'd0;
   localparam logic [1:0] OP_BYTE_END = 2'd1;
   localparam logic [1:0] OP_END      = 2'd2;
   localparam logic [1:0] OP_NONE     = 2'd3;

   // configuration register indexes
   localparam int         CSR_ADDR_W          = 3;
   localparam logic       REG_CRC32_MODE      = 1'b0;
   localparam logic       REG_ESCAPE_CONTROLS = 1'b1;

   // link codes
   localparam logic [7:0] ZDLE_BYTE  = 8'h18;
   localparam logic [7:0] ZCRCW_BYTE = 8'h6B;
   localparam logic [7:0] ZRUB0_BYTE = 8'h6C;
   localparam logic [7:0] ZRUB1_BYTE = 8'h6D;
   localparam logic [7:0] ESC_XOR    = 8'h40;
   localparam logic [6:0] CH_DLE     = 7'h10;
   localparam logic [6:0] CH_XON     = 7'h11;
   localparam logic [6:0] CH_XOFF    = 7'h13;
   localparam logic [6:0] CH_GS      = 7'h1D;
   localparam logic [6:0] CH_CR      = 7'h0D;
   localparam logic [6:0] CH_DEL     = 7'h7F;
   localparam logic [6:0] CH_AT      = 7'h40;
   localparam logic [6:0] CH_SPACE   = 7'h20;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_FF    = 8'hFF;

   // crc constants
   localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;
   localparam logic [15:0] CRC16_POLY = 16'h1021;
   localparam logic [31:0] CRC16_INIT = 32'h0;

   typedef struct packed {
      logic crc32_mode;
      logic escape_controls;
   } cfg_type;

   // one queued word: what the back end has to send
   typedef struct packed {
      logic        has_byte;
      logic        has_end;
      logic [7:0]  data_byte;
      logic [31:0] crc;
   } entry_type;

   // one byte step of either crc
   function automatic logic [31:0] crc_update(input logic [31:0] crc,
                                              input logic [7:0]  b,
                                              input logic        mode32);
      logic [31:0] c32;
      logic [15:0] c16;
      c32 = crc ^ {24'h0, b};
      c16 = crc[15:0] ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c32 = c32[0] ? ((c32 >> 1) ^ CRC32_POLY) : (c32 >> 1);
         c16 = c16[15] ? ((c16 << 1) ^ CRC16_POLY) : (c16 << 1);
      end
      return mode32 ? c32 : {16'h0, c16};
   endfunction

   // does this byte need a zdle prefix
   function automatic logic esc_needed(input logic [7:0] b,
                                       input logic       after_at,
                                       input logic       esc_ctl);
      logic [6:0] low;
      low = b[6:0];
      return (b == ZDLE_BYTE) || (low == CH_DLE) || (low == CH_XON) ||
             (low == CH_XOFF) || (low == CH_GS) || (low == CH_DEL) ||
             (b == BYTE_FF) || ((low == CH_CR) && after_at) ||
             ((low < CH_SPACE) && esc_ctl);
   endfunction

   // byte sent after the zdle prefix
   function automatic logic [7:0] esc_map(input logic [7:0] b);
      logic [7:0] r;
      if (b == BYTE_DEL) begin
         r = ZRUB0_BYTE;
      end else if (b == BYTE_FF) begin
         r = ZRUB1_BYTE;
      end else begin
         r = b ^ ESC_XOR;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/ecsf_fifo.sv]
// ---------------------------------------------------------------------------
// ecsf_fifo
// short word queue between the front end and the back end
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ecsf_fifo #(
   parameter int DEPTH = 2
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  ecsf_pkg::entry_type  push_entry,
   input  wire                  pop,
   output logic                 full,
   output logic                 head_valid,
   output ecsf_pkg::entry_type  head
);
   import ecsf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   `ECSF_ASSERT_IMPL(a_no_push_full, clock, reset, push, count_ff != CW'(DEPTH))
   `ECSF_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, count_ff != '0)
   `ECSF_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))

endmodule

`default_nettype wire

[rtl/ecsf_front.sv]
// ---------------------------------------------------------------------------
// ecsf_front
// accepts input words, runs the payload crc and queues work for the back end
// ---------------------------------------------------------------------------
`default_nettype none

module ecsf_front (
   input  wire                  clock,
   input  wire                  reset,
   input  ecsf_pkg::cfg_type    cfg,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [1:0]           req_op,
   input  wire  [7:0]           req_data_byte,
   input  wire                  q_full,
   output logic                 push,
   output ecsf_pkg::entry_type  push_entry
);
   import ecsf_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic        in_packet_ff, in_packet_in;
   logic        accept;
   logic        has_byte;
   logic        has_end;
   logic [31:0] crc_base;
   logic [31:0] crc_after;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // classify the word
   always_comb begin
      case (req_op)
         OP_BYTE:     begin has_byte = 1'b1; has_end = 1'b0; end
         OP_BYTE_END: begin has_byte = 1'b1; has_end = 1'b1; end
         OP_END:      begin has_byte = 1'b0; has_end = 1'b1; end
         default:     begin has_byte = 1'b0; has_end = 1'b0; end
      endcase
   end

   // running crc, restarted at packet start
   always_comb begin
      crc_base     = in_packet_ff ? crc_ff : (cfg.crc32_mode ? CRC32_INIT : CRC16_INIT);
      crc_after    = has_byte ? crc_update(crc_base, req_data_byte, cfg.crc32_mode)
                              : crc_base;
      crc_in       = crc_ff;
      in_packet_in = in_packet_ff;
      push         = 1'b0;
      if (accept && (has_byte || has_end)) begin
         push         = 1'b1;
         crc_in       = crc_after;
         in_packet_in = !has_end;
      end
   end

   assign push_entry = '{has_byte:  has_byte,
                         has_end:   has_end,
                         data_byte: req_data_byte,
                         crc:       crc_after};

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         in_packet_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         in_packet_ff <= in_packet_in;
      end
   end

endmodule

`default_nettype wire

[rtl/ecsf_back.sv]
// ---------------------------------------------------------------------------
// ecsf_back
// turns queued words into escaped link bytes, one per cycle unless stalled
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ecsf_back (
   input  wire                  clock,
   input  wire                  reset,
   input  ecsf_pkg::cfg_type    cfg,
   input  wire                  head_valid,
   input  ecsf_pkg::entry_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_packet_done
);
   import ecsf_pkg::*;

   typedef enum logic [4:0] {
      S_START = 5'b00001,
      S_ZDLE  = 5'b00010,
      S_ZCRCW = 5'b00100,
      S_CRC   = 5'b01000,
      S_TAIL  = 5'b10000
   } back_state_type;

   back_state_type st_ff, st_in;
   logic [7:0]     tail_ff, tail_in;
   logic           tail_crc_ff, tail_crc_in;
   logic           after_at_ff, after_at_in;
   logic [31:0]    sh_ff, sh_in;
   logic [1:0]     left_ff, left_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_done_ff, rsp_done_in;

   logic           out_free;
   logic           emit;
   logic [7:0]     cur_b;
   logic           esc;
   logic [31:0]    crc_fin;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cur_b    = (st_ff == S_CRC) ? sh_ff[7:0] : head.data_byte;
   assign esc      = esc_needed(cur_b, after_at_ff, cfg.escape_controls);
   assign crc_fin  = crc_update(head.crc, ZCRCW_BYTE, cfg.crc32_mode);

   // byte sequencer
   always_comb begin
      st_in       = st_ff;
      tail_in     = tail_ff;
      tail_crc_in = tail_crc_ff;
      after_at_in = after_at_ff;
      sh_in       = sh_ff;
      left_in     = left_ff;
      emit        = 1'b0;
      pop         = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = 1'b0;
      rsp_done_in = 1'b0;
      case (st_ff)
         S_START: begin
            if (head_valid && out_free) begin
               emit = 1'b1;
               if (head.has_byte) begin
                  after_at_in = (cur_b[6:0] == CH_AT);
                  if (esc) begin
                     rsp_byte_in = ZDLE_BYTE;
                     tail_in     = esc_map(cur_b);
                     tail_crc_in = 1'b0;
                     st_in       = S_TAIL;
                  end else begin
                     rsp_byte_in = cur_b;
                     if (head.has_end) begin
                        st_in = S_ZDLE;
                     end else begin
                        rsp_last_in = 1'b1;
                        pop         = 1'b1;
                     end
                  end
               end else begin
                  rsp_byte_in = ZDLE_BYTE;
                  st_in       = S_ZCRCW;
               end
            end
         end
         S_ZDLE: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = ZDLE_BYTE;
               st_in       = S_ZCRCW;
            end
         end
         S_ZCRCW: begin
            // trailer order: crc-32 inverted low byte first, crc-16 high first
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = ZCRCW_BYTE;
               if (cfg.crc32_mode) begin
                  sh_in   = ~crc_fin;
                  left_in = 2'd3;
               end else begin
                  sh_in   = {16'h0, crc_fin[7:0], crc_fin[15:8]};
                  left_in = 2'd1;
               end
               st_in = S_CRC;
            end
         end
         S_CRC: begin
            if (out_free) begin
               emit        = 1'b1;
               after_at_in = (cur_b[6:0] == CH_AT);
               sh_in       = sh_ff >> 8;
               if (esc) begin
                  rsp_byte_in = ZDLE_BYTE;
                  tail_in     = esc_map(cur_b);
                  tail_crc_in = 1'b1;
                  st_in       = S_TAIL;
               end else begin
                  rsp_byte_in = cur_b;
                  if (left_ff == 2'd0) begin
                     rsp_last_in = 1'b1;
                     rsp_done_in = 1'b1;
                     pop         = 1'b1;
                     st_in       = S_START;
                  end else begin
                     left_in = left_ff - 2'd1;
                  end
               end
            end
         end
         S_TAIL: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_byte_in = tail_ff;
               if (tail_crc_ff) begin
                  if (left_ff == 2'd0) begin
                     rsp_last_in = 1'b1;
                     rsp_done_in = 1'b1;
                     pop         = 1'b1;
                     st_in       = S_START;
                  end else begin
                     left_in = left_ff - 2'd1;
                     st_in   = S_CRC;
                  end
               end else if (head.has_end) begin
                  st_in = S_ZDLE;
               end else begin
                  rsp_last_in = 1'b1;
                  pop         = 1'b1;
                  st_in       = S_START;
               end
            end
         end
         default: begin
            st_in = S_START;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_START;
         after_at_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         after_at_ff  <= after_at_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      tail_crc_ff <= tail_crc_in;
      sh_ff       <= sh_in;
      left_ff     <= left_in;
      if (emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
         rsp_done_ff <= rsp_done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_run_last    = rsp_last_ff;
   assign rsp_packet_done = rsp_done_ff;

   `ECSF_ASSERT_IMPL(a_done_is_last, clock, reset, rsp_valid_ff && rsp_done_ff,
                     rsp_last_ff)
   `ECSF_ASSERT_IMPL(a_busy_has_word, clock, reset, st_ff != S_START, head_valid)
   `ECSF_ASSERT_IMPL(a_tail_after_zdle, clock, reset, st_ff == S_TAIL,
                     rsp_valid_ff && (rsp_byte_ff == ZDLE_BYTE))

endmodule

`default_nettype wire

[rtl/escaped_crc_subpacket_framer_core.sv]
// ---------------------------------------------------------------------------
// escaped_crc_subpacket_framer_core
// zdle-escaped data subpacket framer with crc-16 / crc-32 trailer
// ---------------------------------------------------------------------------
//  channel  prefix  direction  word
//  input    req_    in         op, data_byte
//  output   rsp_    out        out_byte, run_last, packet_done
//  config   csr_    in/out     apb-style register port, 32-bit data
//
//  the back end sends one link byte per cycle from its output register:
//  a plain payload byte goes out as is, an escaped one as zdle + mapped
//  byte; a packet end adds zdle/zcrcw plus 2 (crc-16) or 4 (crc-32) crc
//  bytes, each escaped as needed. the front end accepts one word per cycle
//  while the QUEUE_DEPTH-word queue has room. reset is synchronous; no
//  clearing pass. output stalls hold the byte and back up into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module escaped_crc_subpacket_framer_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [1:0]                         req_op,
   input  wire  [7:0]                         req_data_byte,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_run_last,
   output logic                               rsp_packet_done,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [ecsf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import ecsf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_wr;
   logic       csr_idx;
   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_head_valid;
   entry_type  q_push_entry;
   entry_type  q_head;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_CRC32_MODE:      cfg_in.crc32_mode      = csr_pwdata[0];
            REG_ESCAPE_CONTROLS: cfg_in.escape_controls = csr_pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_CRC32_MODE:      csr_prdata = {31'h0, cfg_ff.crc32_mode};
         REG_ESCAPE_CONTROLS: csr_prdata = {31'h0, cfg_ff.escape_controls};
         default:             csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accept side
   ecsf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .push          (q_push),
      .push_entry    (q_push_entry)
   );

   // word queue
   ecsf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // send side
   ecsf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head_valid      (q_head_valid),
      .head            (q_head),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_packet_done (rsp_packet_done)
   );

endmodule

`default_nettype wire

[dv/tb_escaped_crc_subpacket_framer_core.sv]
// ---------------------------------------------------------------------------
// tb_escaped_crc_subpacket_framer_core
// self-checking bench for the zdle-escaped crc subpacket framer
// ---------------------------------------------------------------------------
// a short table of directed words runs first. rows whose link bytes are
// obvious carry them typed in, and every other word is checked against a
// behavioral model of the framer kept in the bench. random phases follow,
// mostly well-formed subpackets with bytes biased toward the escape set,
// with both crc modes and both escape options. the bench idles the input
// and stalls the output in random bursts. link bytes are compared field
// by field, in order, against the expected stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_escaped_crc_subpacket_framer_core;
   import ecsf_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int LIMIT_CYCLES  = 250000;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_WORDS   = 26;
   localparam int NUM_PHASES    = 6;
   localparam int MAX_REPORTS   = 10;

   localparam logic [CSR_ADDR_W-1:0] ADDR_CRC32 = {REG_CRC32_MODE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_ESC   = {REG_ESCAPE_CONTROLS, 2'b00};

   // one link byte as it leaves the framer
   typedef struct {
      logic [7:0] b;
      logic       last;
      logic       done;
   } link_byte_type;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;

   // directed row: a word, or a register setting; n_fixed < 0 means predicted
   typedef struct {
      row_kind_type kind;
      logic [1:0]   op;
      logic [7:0]   data;
      int           n_fixed;
      logic [7:0]   fx0;
      logic [7:0]   fx1;
      logic         crc32;
      logic         esc;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op = OP_BYTE;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_run_last;
   logic                  rsp_packet_done;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   escaped_crc_subpacket_framer_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_packet_done (rsp_packet_done),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #4 clock = ~clock;

   // directed words; typed link bytes only where they are plain to see
   dir_row_type dir_tab [25] = '{
      '{ROW_CSR,  OP_NONE,     8'h00, 0,  8'h00,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_NONE,     8'h55, 0,  8'h00,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h00, 1,  8'h00,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'hFF, 2,  ZDLE_BYTE, ZRUB1_BYTE, 1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h7F, 2,  ZDLE_BYTE, ZRUB0_BYTE, 1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h18, 2,  ZDLE_BYTE, 8'h58,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h98, 1,  8'h98,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h10, 2,  ZDLE_BYTE, 8'h50,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h91, 2,  ZDLE_BYTE, 8'hD1,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h13, 2,  ZDLE_BYTE, 8'h53,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h9D, 2,  ZDLE_BYTE, 8'hDD,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h40, 1,  8'h40,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h0D, 2,  ZDLE_BYTE, 8'h4D,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h8D, 1,  8'h8D,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'hC0, 1,  8'hC0,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h8D, 2,  ZDLE_BYTE, 8'hCD,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE_END, 8'h55, -1, 8'h00,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_END,      8'h00, -1, 8'h00,     8'h00,      1'b0, 1'b0},
      '{ROW_CSR,  OP_NONE,     8'h00, 0,  8'h00,     8'h00,      1'b1, 1'b1},
      '{ROW_WORD, OP_BYTE,     8'h01, 2,  ZDLE_BYTE, 8'h41,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h98, 2,  ZDLE_BYTE, 8'hD8,      1'b0, 1'b0},
      '{ROW_WORD, OP_END,      8'hAA, -1, 8'h00,     8'h00,      1'b0, 1'b0},
      '{ROW_WORD, OP_BYTE,     8'h3C, -1, 8'h00,     8'h00,      1'b0, 1'b0},
      '{ROW_CSR,  OP_NONE,     8'h00, 0,  8'h00,     8'h00,      1'b0, 1'b1},
      '{ROW_WORD, OP_BYTE_END, 8'hA5, -1, 8'h00,     8'h00,      1'b0, 1'b0}
   };

   // framer model state and its copy of the registers
   logic [31:0] crc_acc   = '0;
   logic        in_pkt    = 1'b0;
   logic        at_seen   = 1'b0;
   logic        cfg_crc32 = 1'b0;
   logic        cfg_esc   = 1'b0;

   link_byte_type link_bytes_q[$];
   link_byte_type word_bytes[$];

   // typed link bytes that go with the word on the input channel
   int          typed_n = -1;
   logic [7:0]  typed_b0 = 8'h00;
   logic [7:0]  typed_b1 = 8'h00;

   int          fail_count = 0;
   int          cycle_count = 0;
   int          gap_pct = 0;
   int          stall_pct = 20;
   int          stall_left = 0;
   int          hold_left = 0;
   bit          hold_req = 1'b0;

   function automatic void note_fail(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("ERROR: %s", msg);
      end
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      link_byte_type e;
      e.b = b;
      e.last = 1'b0;
      e.done = 1'b0;
      word_bytes.push_back(e);
   endfunction

   // one byte into the running crc, in the mode set right now
   function automatic void crc_step(input logic [7:0] b);
      logic [31:0] c;
      logic [15:0] h;
      int          i;
      if (cfg_crc32) begin
         c = crc_acc ^ {24'h0, b};
         for (i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
         end
         crc_acc = c;
      end else begin
         h = crc_acc[15:0] ^ {b, 8'h00};
         for (i = 0; i < 8; i++) begin
            h = h[15] ? ((h << 1) ^ CRC16_POLY) : (h << 1);
         end
         crc_acc = {16'h0, h};
      end
   endfunction

   // zdle escape of one payload or crc byte
   function automatic void add_escaped(input logic [7:0] b);
      logic [6:0] low;
      logic       esc;
      low = b[6:0];
      case (low)
         CH_DLE, CH_XON, CH_XOFF, CH_GS, CH_DEL: esc = 1'b1;
         default: esc = 1'b0;
      endcase
      esc = esc | (b == ZDLE_BYTE) | (b == BYTE_FF) | ((low == CH_CR) & at_seen) |
            ((low < CH_SPACE) & cfg_esc);
      if (esc) begin
         add_byte(ZDLE_BYTE);
         if (b == BYTE_DEL) begin
            add_byte(ZRUB0_BYTE);
         end else if (b == BYTE_FF) begin
            add_byte(ZRUB1_BYTE);
         end else begin
            add_byte(b ^ ESC_XOR);
         end
      end else begin
         add_byte(b);
      end
      at_seen = (low == CH_AT);
   endfunction

   // link bytes caused by one input word, left in word_bytes
   function automatic void frame_predict(input logic [1:0] op, input logic [7:0] b);
      logic [31:0]   inv;
      logic          ends;
      link_byte_type e;
      int            i;
      word_bytes.delete();
      if (op == OP_NONE) begin
         return;
      end
      if (!in_pkt) begin
         crc_acc = cfg_crc32 ? CRC32_INIT : CRC16_INIT;
         in_pkt = 1'b1;
      end
      if (op != OP_END) begin
         crc_step(b);
         add_escaped(b);
      end
      ends = (op != OP_BYTE);
      if (ends) begin
         add_byte(ZDLE_BYTE);
         crc_step(ZCRCW_BYTE);
         add_byte(ZCRCW_BYTE);
         if (cfg_crc32) begin
            inv = ~crc_acc;
            for (i = 0; i < 4; i++) begin
               add_escaped(inv[7:0]);
               inv = inv >> 8;
            end
         end else begin
            add_escaped(crc_acc[15:8]);
            add_escaped(crc_acc[7:0]);
         end
         in_pkt = 1'b0;
      end
      e = word_bytes.pop_back();
      e.last = 1'b1;
      e.done = ends;
      word_bytes.push_back(e);
   endfunction

   // payload byte biased toward the escape set, either parity
   function automatic logic [7:0] pick_payload();
      logic [6:0] low;
      logic [7:0] b;
      case ($urandom_range(0, 3))
         1: begin
            case ($urandom_range(0, 7))
               0: low = CH_DLE;
               1: low = CH_XON;
               2: low = CH_XOFF;
               3: low = CH_GS;
               4: low = CH_DEL;
               5: low = CH_CR;
               6: low = CH_AT;
               default: low = ZDLE_BYTE[6:0];
            endcase
            b = {1'($urandom_range(0, 1)), low};
         end
         2: b = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 31))};
         default: b = 8'($urandom);
      endcase
      return b;
   endfunction

   // register writes, accepted words and link bytes, all at the rising edge
   always @(posedge clock) begin : monitor
      link_byte_type e;
      int            i;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         if (csr_paddr == ADDR_CRC32) begin
            cfg_crc32 = csr_pwdata[0];
         end else if (csr_paddr == ADDR_ESC) begin
            cfg_esc = csr_pwdata[0];
         end
      end
      if (req_valid && req_ready) begin
         frame_predict(req_op, req_data_byte);
         if (typed_n < 0) begin
            foreach (word_bytes[i]) begin
               link_bytes_q.push_back(word_bytes[i]);
            end
         end else begin
            for (i = 0; i < typed_n; i++) begin
               e.b = (i == 0) ? typed_b0 : typed_b1;
               e.last = (i == typed_n - 1);
               e.done = 1'b0;
               link_bytes_q.push_back(e);
            end
         end
      end
      if (rsp_valid && rsp_ready) begin
         if (link_bytes_q.size() == 0) begin
            note_fail($sformatf("unexpected link byte %h last %b done %b",
                                rsp_out_byte, rsp_run_last, rsp_packet_done));
         end else begin
            e = link_bytes_q.pop_front();
            if (e.b !== rsp_out_byte || e.last !== rsp_run_last ||
                e.done !== rsp_packet_done) begin
               note_fail($sformatf("link byte exp %h last %b done %b, got %h last %b done %b",
                                   e.b, e.last, e.done,
                                   rsp_out_byte, rsp_run_last, rsp_packet_done));
            end
         end
      end
   end

   // receiver: long hold on request, else random stall bursts
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("escaped_crc_subpacket_framer_core test failed");
         $finish;
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [7:0] b, input int n,
                            input logic [7:0] f0, input logic [7:0] f1);
      @(negedge clock);
      req_valid <= 1'b1;
      req_op <= op;
      req_data_byte <= b;
      typed_n = n;
      typed_b0 = f0;
      typed_b1 = f1;
      @(posedge clock);
      while (req_ready !== 1'b1) begin
         @(posedge clock);
      end
   endtask

   task automatic idle_sender(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic send_random(input logic [1:0] op, input logic [7:0] b);
      if ($urandom_range(0, 99) < gap_pct) begin
         idle_sender($urandom_range(1, 14));
      end
      send_word(op, b, -1, 8'h00, 8'h00);
   endtask

   // stop sending until every expected link byte is out
   task automatic drain();
      idle_sender(1);
      while (link_bytes_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(input logic crc32, input logic esc);
      drain();
      csr_write(ADDR_CRC32, {31'h0, crc32});
      csr_write(ADDR_ESC, {31'h0, esc});
   endtask

   initial begin : stimulus
      int         p;
      int         count;
      int         len;
      int         j;
      bit         quiet;
      bit         paused;
      logic       at_prev;
      logic [1:0] op;
      logic [7:0] b;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_tab[j]) begin
         if (dir_tab[j].kind == ROW_CSR) begin
            set_config(dir_tab[j].crc32, dir_tab[j].esc);
         end else begin
            send_word(dir_tab[j].op, dir_tab[j].data, dir_tab[j].n_fixed,
                      dir_tab[j].fx0, dir_tab[j].fx1);
         end
      end

      // random phases; a phase may end inside a packet
      paused = 1'b0;
      for (p = 0; p < NUM_PHASES; p++) begin
         quiet = (p == NUM_PHASES - 1);
         case (p)
            0: set_config(1'b0, 1'b0);
            1: set_config(1'b1, 1'b1);
            2: set_config(1'b1, 1'b0);
            3: set_config(1'b0, 1'b1);
            default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         endcase
         gap_pct = quiet ? 0 : $urandom_range(0, 40);
         stall_pct = quiet ? 0 : $urandom_range(0, 40);
         if (p == 1) begin
            hold_req = 1'b1;
         end
         count = 0;
         while (count < PHASE_WORDS) begin
            if (p == 3 && !paused && count >= PHASE_WORDS / 2) begin
               drain();
               paused = 1'b1;
            end
            case ($urandom_range(0, 19))
               0: send_random(OP_NONE, 8'($urandom));
               1: begin
                  send_random(OP_END, 8'($urandom));
                  count++;
               end
               default: begin
                  len = $urandom_range(0, 10);
                  at_prev = 1'b0;
                  for (j = 0; j <= len && count < PHASE_WORDS; j++) begin
                     if (at_prev && $urandom_range(0, 1)) begin
                        b = {1'($urandom_range(0, 1)), CH_CR};
                     end else begin
                        b = pick_payload();
                     end
                     at_prev = (b[6:0] == CH_AT);
                     if (j < len) begin
                        op = OP_BYTE;
                     end else begin
                        op = $urandom_range(0, 1) ? OP_BYTE_END : OP_END;
                     end
                     send_random(op, b);
                     count++;
                  end
               end
            endcase
         end
      end

      // wind down
      idle_sender(1);
      stall_pct = 0;
      while (link_bytes_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("escaped_crc_subpacket_framer_core test passed");
      end else begin
         $display("escaped_crc_subpacket_framer_core test failed");
      end
      $finish;
   end

endmodule
